>>> src/neutral_loss_mass_match_top_defines.svh
// assertion macros for the neutral-loss mass matcher checker
`ifndef NEUTRAL_LOSS_MASS_MATCH_TOP_DEFINES_SVH
`define NEUTRAL_LOSS_MASS_MATCH_TOP_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define NLMM_ASSERT_NOW(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("nlmm port check failed");

// consequent must hold in the cycle after the antecedent
`define NLMM_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("nlmm port check failed");

`endif

>>> src/nlmm_pkg.sv
// shared types and constants of the neutral-loss mass matcher
package nlmm_pkg;

    // table geometry
    localparam int TABLE_DEPTH = 32;
    localparam int CNT_W       = 7;

    // field widths
    localparam int MASS_W  = 31;
    localparam int LABEL_W = 16;
    localparam int ID_W    = 16;
    localparam int MDIFF_W = 32;
    localparam int RT_W    = 23;
    localparam int IDX_IN_W = 5;
    localparam int ERR_W   = 33;
    localparam int PROD_E_W = 53;
    localparam int PROD_M_W = 41;

    // configuration register widths and reset values
    localparam int TOL_ABS_W = 20;
    localparam int TOL_PPM_W = 10;
    localparam int RT_LIM_W  = 22;
    localparam int EIU_W     = 6;
    localparam logic [TOL_ABS_W-1:0] TOL_ABS_RST = 20'd5000;
    localparam logic [TOL_PPM_W-1:0] TOL_PPM_RST = 10'd10;
    localparam logic [RT_LIM_W-1:0]  RT_LIM_RST  = 22'd10000;
    localparam logic [EIU_W-1:0]     EIU_RST     = 6'd0;

    // ppm scale factor
    localparam logic [19:0] PPM_SCALE = 20'd1000000;

    // item commands
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // register map, index = paddr[3:2]
    typedef enum logic [1:0] {
        REG_TOL_ABS = 2'd0,
        REG_TOL_PPM = 2'd1,
        REG_RT_LIM  = 2'd2,
        REG_EIU     = 2'd3
    } nlmm_reg_t;

    // control states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN
    } nlmm_state_t;

    // entry handed from the ring head to the matcher
    typedef struct packed {
        logic               valid;
        logic [MASS_W-1:0]  mass;
        logic [LABEL_W-1:0] label;
    } nlmm_issue_t;

    // verdict from the matcher
    typedef struct packed {
        logic               valid;
        logic               match;
        logic [LABEL_W-1:0] label;
    } nlmm_hit_t;

endpackage

>>> src/nlmm_if.sv
// valid/ready channel interfaces for input items and result items

interface nlmm_in_if;
    logic                              valid;
    logic                              ready;
    logic                              cmd;
    logic [nlmm_pkg::IDX_IN_W-1:0]     entry_index;
    logic [nlmm_pkg::MASS_W-1:0]       entry_mass;
    logic [nlmm_pkg::LABEL_W-1:0]      entry_label;
    logic signed [nlmm_pkg::MDIFF_W-1:0] pair_mass_diff;
    logic signed [nlmm_pkg::RT_W-1:0]  pair_rt_diff;
    logic [nlmm_pkg::MASS_W-1:0]       first_mz;
    logic [nlmm_pkg::MASS_W-1:0]       second_mz;
    logic [nlmm_pkg::ID_W-1:0]         first_id;
    logic [nlmm_pkg::ID_W-1:0]         second_id;

    modport source (
        output valid, cmd, entry_index, entry_mass, entry_label, pair_mass_diff,
               pair_rt_diff, first_mz, second_mz, first_id, second_id,
        input  ready
    );
    modport sink (
        input  valid, cmd, entry_index, entry_mass, entry_label, pair_mass_diff,
               pair_rt_diff, first_mz, second_mz, first_id, second_id,
        output ready
    );
endinterface

interface nlmm_out_if;
    logic                         valid;
    logic                         ready;
    logic                         found;
    logic [nlmm_pkg::ID_W-1:0]    high_id;
    logic [nlmm_pkg::ID_W-1:0]    low_id;
    logic [nlmm_pkg::LABEL_W-1:0] loss_label;
    logic                         last;

    modport source (
        output valid, found, high_id, low_id, loss_label, last,
        input  ready
    );
    modport sink (
        input  valid, found, high_id, low_id, loss_label, last,
        output ready
    );
endinterface

>>> src/nlmm_cell.sv
// one table slot of the rotating entry ring
module nlmm_cell (
    input  logic                         clk,
    input  logic                         load_en,
    input  logic [nlmm_pkg::MASS_W-1:0]  load_mass,
    input  logic [nlmm_pkg::LABEL_W-1:0] load_label,
    input  logic                         shift_en,
    input  logic [nlmm_pkg::MASS_W-1:0]  nbr_mass,
    input  logic [nlmm_pkg::LABEL_W-1:0] nbr_label,
    output logic [nlmm_pkg::MASS_W-1:0]  mass,
    output logic [nlmm_pkg::LABEL_W-1:0] label
);

    logic [nlmm_pkg::MASS_W-1:0]  mass_reg;
    logic [nlmm_pkg::MASS_W-1:0]  mass_next;
    logic [nlmm_pkg::LABEL_W-1:0] label_reg;
    logic [nlmm_pkg::LABEL_W-1:0] label_next;

    // load from the input beat, or take the neighbor's entry on a ring step
    always_comb
    begin
        mass_next  = mass_reg;
        label_next = label_reg;
        if (load_en)
        begin
            mass_next  = load_mass;
            label_next = load_label;
        end
        else if (shift_en)
        begin
            mass_next  = nbr_mass;
            label_next = nbr_label;
        end
    end

    // entry contents, undefined until loaded
    always_ff @(posedge clk)
    begin
        mass_reg  <= mass_next;
        label_reg <= label_next;
    end

    assign mass  = mass_reg;
    assign label = label_reg;

endmodule

>>> src/nlmm_matcher.sv
// two-stage tolerance test of one table entry against the current query
module nlmm_matcher (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                adv,
    input  nlmm_pkg::nlmm_issue_t               issue,
    input  logic signed [nlmm_pkg::MDIFF_W-1:0] mass_diff,
    input  logic [nlmm_pkg::TOL_ABS_W-1:0]      tol_abs,
    input  logic [nlmm_pkg::TOL_PPM_W-1:0]      tol_ppm,
    output nlmm_pkg::nlmm_hit_t                 hit,
    output logic                                busy
);

    localparam int DIFF_W = nlmm_pkg::ERR_W + 1;

    logic                           s1_valid_reg;
    logic                           s1_valid_next;
    logic [nlmm_pkg::ERR_W-1:0]     s1_err_reg;
    logic [nlmm_pkg::ERR_W-1:0]     s1_err_next;
    logic [nlmm_pkg::MASS_W-1:0]    s1_mass_reg;
    logic [nlmm_pkg::LABEL_W-1:0]   s1_label_reg;

    logic                           s2_valid_reg;
    logic                           s2_valid_next;
    logic                           s2_abs_ok_reg;
    logic                           s2_abs_ok_next;
    logic [nlmm_pkg::PROD_E_W-1:0]  s2_prod_err_reg;
    logic [nlmm_pkg::PROD_E_W-1:0]  s2_prod_err_next;
    logic [nlmm_pkg::PROD_M_W-1:0]  s2_prod_tol_reg;
    logic [nlmm_pkg::PROD_M_W-1:0]  s2_prod_tol_next;
    logic [nlmm_pkg::LABEL_W-1:0]   s2_label_reg;

    logic signed [DIFF_W-1:0]       diff;
    logic signed [DIFF_W-1:0]       diff_neg;

    // stage 1: absolute mass error
    always_comb
    begin
        diff = $signed({3'b000, issue.mass})
             - $signed({{(DIFF_W-nlmm_pkg::MDIFF_W){mass_diff[nlmm_pkg::MDIFF_W-1]}},
                        mass_diff});
        diff_neg    = -diff;
        s1_err_next = diff[DIFF_W-1] ? diff_neg[nlmm_pkg::ERR_W-1:0]
                                     : diff[nlmm_pkg::ERR_W-1:0];
        s1_valid_next = issue.valid;
    end

    // stage 2: absolute test and both sides of the ppm test
    always_comb
    begin
        s2_valid_next    = s1_valid_reg;
        s2_abs_ok_next   = s1_err_reg <= nlmm_pkg::ERR_W'(tol_abs);
        s2_prod_err_next = nlmm_pkg::PROD_E_W'(s1_err_reg)
                         * nlmm_pkg::PROD_E_W'(nlmm_pkg::PPM_SCALE);
        s2_prod_tol_next = nlmm_pkg::PROD_M_W'(s1_mass_reg)
                         * nlmm_pkg::PROD_M_W'(tol_ppm);
    end

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_err_reg      <= s1_err_next;
            s1_mass_reg     <= issue.mass;
            s1_label_reg    <= issue.label;
            s2_abs_ok_reg   <= s2_abs_ok_next;
            s2_prod_err_reg <= s2_prod_err_next;
            s2_prod_tol_reg <= s2_prod_tol_next;
            s2_label_reg    <= s1_label_reg;
        end
    end

    // final compare
    always_comb
    begin
        hit.valid = s2_valid_reg;
        hit.match = s2_abs_ok_reg
                  || (s2_prod_err_reg <= nlmm_pkg::PROD_E_W'(s2_prod_tol_reg));
        hit.label = s2_label_reg;
    end

    assign busy = s1_valid_reg || s2_valid_reg;

endmodule

>>> src/neutral_loss_mass_match_top.sv
// top level of the neutral-loss mass matcher: register port, entry ring, control, output
//
// Load beats (cmd=0) write one slot of a ring of DEPTH cells. A query beat (cmd=1)
// rotates the ring once around, DEPTH steps, while the head cell feeds a two-stage
// tolerance matcher; after the matcher drains and the closing beat is loaded the
// block is ready again. A sink that holds a result stalls the ring and the matcher.
// Matches come out in table order, the final one with last=1; a query with no
// match gives one beat with found=0 and last=1. The ring turn sets the query time.
// Table slots hold nothing defined until loaded; the tolerance registers and
// entries_in_use are written over the APB port at byte address 4*index; the user
// must write them only while no query is in flight; the block does not enforce it.
module neutral_loss_mass_match_top #(
    parameter int DEPTH = nlmm_pkg::TABLE_DEPTH
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    nlmm_in_if.sink      in_ch,
    nlmm_out_if.source   out_ch
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = nlmm_pkg::CNT_W;

    // configuration registers
    logic [nlmm_pkg::TOL_ABS_W-1:0] tol_abs_reg;
    logic [nlmm_pkg::TOL_PPM_W-1:0] tol_ppm_reg;
    logic [nlmm_pkg::RT_LIM_W-1:0]  rt_lim_reg;
    logic [nlmm_pkg::EIU_W-1:0]     eiu_reg;
    logic                           cfg_wr;

    // control
    nlmm_pkg::nlmm_state_t          state_reg;
    nlmm_pkg::nlmm_state_t          state_next;
    logic [IDX_W-1:0]               rot_cnt_reg;
    logic [IDX_W-1:0]               rot_cnt_next;
    logic [CNT_W-1:0]               n_reg;
    logic [CNT_W-1:0]               n_next;
    logic                           adv;
    logic                           in_fire;
    logic                           load_fire;
    logic                           query_fire;
    logic                           shift_en;
    logic                           scan_done;
    logic                           close_fire;
    logic                           hit_fire;
    logic                           in_ready;

    // query context
    logic signed [nlmm_pkg::MDIFF_W-1:0] mdiff_reg;
    logic                           rt_ok_reg;
    logic                           rt_ok_next;
    logic [nlmm_pkg::ID_W-1:0]      high_reg;
    logic [nlmm_pkg::ID_W-1:0]      high_next;
    logic [nlmm_pkg::ID_W-1:0]      low_reg;
    logic [nlmm_pkg::ID_W-1:0]      low_next;

    // held match, sent once the next one shows whether it is the final one
    logic                           pend_valid_reg;
    logic                           pend_valid_next;
    logic [nlmm_pkg::LABEL_W-1:0]   pend_label_reg;
    logic [nlmm_pkg::LABEL_W-1:0]   pend_label_next;

    // output register
    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic                           out_load;
    logic                           out_found_reg;
    logic                           out_found_next;
    logic                           out_last_reg;
    logic                           out_last_next;
    logic [nlmm_pkg::LABEL_W-1:0]   out_label_reg;
    logic [nlmm_pkg::LABEL_W-1:0]   out_label_next;
    logic [nlmm_pkg::ID_W-1:0]      out_high_reg;
    logic [nlmm_pkg::ID_W-1:0]      out_low_reg;

    // ring and matcher
    logic [nlmm_pkg::MASS_W-1:0]    cell_mass  [DEPTH];
    logic [nlmm_pkg::LABEL_W-1:0]   cell_label [DEPTH];
    nlmm_pkg::nlmm_issue_t          issue;
    nlmm_pkg::nlmm_hit_t            hit;
    logic                           busy;
    logic [CNT_W-1:0]               eiu_ext;

    // apb register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_abs_reg <= nlmm_pkg::TOL_ABS_RST;
            tol_ppm_reg <= nlmm_pkg::TOL_PPM_RST;
            rt_lim_reg  <= nlmm_pkg::RT_LIM_RST;
            eiu_reg     <= nlmm_pkg::EIU_RST;
        end
        else if (cfg_wr)
        begin
            unique case (nlmm_pkg::nlmm_reg_t'(paddr[3:2]))
                nlmm_pkg::REG_TOL_ABS: tol_abs_reg <= pwdata[nlmm_pkg::TOL_ABS_W-1:0];
                nlmm_pkg::REG_TOL_PPM: tol_ppm_reg <= pwdata[nlmm_pkg::TOL_PPM_W-1:0];
                nlmm_pkg::REG_RT_LIM:  rt_lim_reg  <= pwdata[nlmm_pkg::RT_LIM_W-1:0];
                nlmm_pkg::REG_EIU:     eiu_reg     <= pwdata[nlmm_pkg::EIU_W-1:0];
            endcase
        end
    end

    // register readback
    always_comb
    begin
        unique case (nlmm_pkg::nlmm_reg_t'(paddr[3:2]))
            nlmm_pkg::REG_TOL_ABS: prdata = 32'(tol_abs_reg);
            nlmm_pkg::REG_TOL_PPM: prdata = 32'(tol_ppm_reg);
            nlmm_pkg::REG_RT_LIM:  prdata = 32'(rt_lim_reg);
            nlmm_pkg::REG_EIU:     prdata = 32'(eiu_reg);
        endcase
    end

    // handshake qualifiers
    assign adv        = !out_valid_reg || out_ch.ready;
    assign in_fire    = in_ch.valid && in_ready;
    assign load_fire  = in_fire && (in_ch.cmd == nlmm_pkg::CMD_LOAD);
    assign query_fire = in_fire && (in_ch.cmd == nlmm_pkg::CMD_QUERY);
    assign scan_done  = rot_cnt_reg == IDX_W'(DEPTH - 1);
    assign hit_fire   = adv && hit.valid && hit.match && rt_ok_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            nlmm_pkg::ST_IDLE:
            begin
                if (query_fire)
                begin
                    state_next = nlmm_pkg::ST_SCAN;
                end
            end
            nlmm_pkg::ST_SCAN:
            begin
                if (shift_en && scan_done)
                begin
                    state_next = nlmm_pkg::ST_DRAIN;
                end
            end
            nlmm_pkg::ST_DRAIN:
            begin
                if (close_fire)
                begin
                    state_next = nlmm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = nlmm_pkg::ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        in_ready   = 1'b0;
        shift_en   = 1'b0;
        close_fire = 1'b0;
        unique case (state_reg)
            nlmm_pkg::ST_IDLE:  in_ready   = 1'b1;
            nlmm_pkg::ST_SCAN:  shift_en   = adv;
            nlmm_pkg::ST_DRAIN: close_fire = adv && !busy;
            default:            in_ready   = 1'b0;
        endcase
    end

    assign in_ch.ready = in_ready;

    // scan counter and query context
    always_comb
    begin
        eiu_ext      = CNT_W'(eiu_reg);
        rot_cnt_next = rot_cnt_reg;
        n_next       = n_reg;
        if (query_fire)
        begin
            rot_cnt_next = '0;
            n_next = (eiu_ext > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : eiu_ext;
        end
        else if (shift_en)
        begin
            rot_cnt_next = rot_cnt_reg + 1'b1;
        end
        rt_ok_next = in_ch.pair_rt_diff <= $signed({1'b0, rt_lim_reg});
        high_next  = (in_ch.first_mz < in_ch.second_mz) ? in_ch.second_id : in_ch.first_id;
        low_next   = (in_ch.first_mz < in_ch.second_mz) ? in_ch.first_id : in_ch.second_id;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= nlmm_pkg::ST_IDLE;
            rot_cnt_reg <= '0;
            n_reg       <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            rot_cnt_reg <= rot_cnt_next;
            n_reg       <= n_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (query_fire)
        begin
            mdiff_reg <= in_ch.pair_mass_diff;
            rt_ok_reg <= rt_ok_next;
            high_reg  <= high_next;
            low_reg   <= low_next;
        end
    end

    // entry ring, cell k takes cell k+1 on each step
    for (genvar k = 0; k < DEPTH; k++)
    begin : g_cell
        nlmm_cell u_cell (
            .clk        (clk),
            .load_en    (load_fire && (int'(in_ch.entry_index) == k)),
            .load_mass  (in_ch.entry_mass),
            .load_label (in_ch.entry_label),
            .shift_en   (shift_en),
            .nbr_mass   (cell_mass[(k + 1) % DEPTH]),
            .nbr_label  (cell_label[(k + 1) % DEPTH]),
            .mass       (cell_mass[k]),
            .label      (cell_label[k])
        );
    end

    // ring head feeds the matcher while the slot is in use
    always_comb
    begin
        issue.valid = shift_en && (CNT_W'(rot_cnt_reg) < n_reg);
        issue.mass  = cell_mass[0];
        issue.label = cell_label[0];
    end

    nlmm_matcher u_matcher (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .issue     (issue),
        .mass_diff (mdiff_reg),
        .tol_abs   (tol_abs_reg),
        .tol_ppm   (tol_ppm_reg),
        .hit       (hit),
        .busy      (busy)
    );

    // held match and result beat
    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_label_next = pend_label_reg;
        out_load        = 1'b0;
        out_found_next  = out_found_reg;
        out_label_next  = out_label_reg;
        out_last_next   = out_last_reg;
        if (hit_fire)
        begin
            pend_valid_next = 1'b1;
            pend_label_next = hit.label;
            if (pend_valid_reg)
            begin
                out_load       = 1'b1;
                out_found_next = 1'b1;
                out_label_next = pend_label_reg;
                out_last_next  = 1'b0;
            end
        end
        else if (close_fire)
        begin
            pend_valid_next = 1'b0;
            out_load        = 1'b1;
            out_found_next  = pend_valid_reg;
            out_label_next  = pend_valid_reg ? pend_label_reg : '0;
            out_last_next   = 1'b1;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_label_reg <= pend_label_next;
        if (out_load)
        begin
            out_found_reg <= out_found_next;
            out_label_reg <= out_label_next;
            out_last_reg  <= out_last_next;
            out_high_reg  <= high_reg;
            out_low_reg   <= low_reg;
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.found      = out_found_reg;
    assign out_ch.high_id    = out_high_reg;
    assign out_ch.low_id     = out_low_reg;
    assign out_ch.loss_label = out_label_reg;
    assign out_ch.last       = out_last_reg;

endmodule

>>> src/nlmm_checker.sv
// port-level checks of the neutral-loss mass matcher, bound to the top level
`include "neutral_loss_mass_match_top_defines.svh"

module nlmm_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         in_cmd,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic                         out_found,
    input logic [nlmm_pkg::ID_W-1:0]    out_high_id,
    input logic [nlmm_pkg::ID_W-1:0]    out_low_id,
    input logic [nlmm_pkg::LABEL_W-1:0] out_loss_label,
    input logic                         out_last
);

    // a stalled result beat keeps its contents
    `NLMM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_found) && $stable(out_high_id) && $stable(out_low_id) && $stable(out_loss_label) && $stable(out_last))

    // a no-match beat always closes the query
    `NLMM_ASSERT_NOW(a_nomatch_last, clk, rst_n, out_valid && !out_found, out_last)

    // while ready for the next item, only the closing beat can still wait
    `NLMM_ASSERT_NOW(a_ready_close, clk, rst_n, in_ready && out_valid, out_last)

    // an accepted query blocks the input in the following cycle
    `NLMM_ASSERT_NEXT(a_query_busy, clk, rst_n, in_valid && in_ready && in_cmd == nlmm_pkg::CMD_QUERY, !in_ready)

endmodule

bind neutral_loss_mass_match_top nlmm_checker u_nlmm_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .in_cmd         (in_ch.cmd),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_found      (out_ch.found),
    .out_high_id    (out_ch.high_id),
    .out_low_id     (out_ch.low_id),
    .out_loss_label (out_ch.loss_label),
    .out_last       (out_ch.last)
);
